>>> rtl/dgsp_pkg.sv
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared types, codes and helpers for the dense-graph shortest path block.
// ----------------------------------------------------------------------------
`default_nettype none

package dgsp_pkg;

  localparam int unsigned MaxVertices = 32;
  localparam int unsigned VtxW  = $clog2(MaxVertices);
  localparam int unsigned CntW  = VtxW + 1;
  localparam int unsigned WgtW  = 18;
  localparam int unsigned DistW = 24;
  localparam int unsigned ActW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ResultLimit = 32;
  localparam int unsigned KW = $clog2(ResultLimit);
  localparam logic [DistW-1:0] CapReset = 24'd255744;
  localparam logic [CntW-1:0] CountReset = 6'd18;
  localparam logic [VtxW:0] ParentNone = {1'b1, {VtxW{1'b1}}};

  localparam logic [ActW-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ActW-1:0] ACT_RUN   = 2'd1;
  localparam logic [ActW-1:0] ACT_QUERY = 2'd2;

  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_PATH = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_COUNT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SOURCE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CAP    = 2'd2;

  typedef struct packed {
    logic [CntW-1:0]  vertex_count;
    logic [VtxW-1:0]  source_vertex;
    logic [DistW-1:0] no_path_value;
  } cfg_t;

  typedef struct packed {
    logic            load;
    logic            clear_run;
    logic            scan_en;
    logic            scan_first;
    logic            settle;
    logic            rd_en;
    logic [VtxW-1:0] idx;
    logic            emit_run;
    logic            q_start;
    logic            q_emit;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic best_lt_cap;
    logic out_free;
    logic more;
  } sts_t;

  function automatic logic [CntW-1:0] eff_count(input logic [CntW-1:0] vc);
    logic [CntW-1:0] lim;
    lim = CntW'(MaxVertices);
    return (vc > lim) ? lim : vc;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dgsp_ctrl.sv
// ----------------------------------------------------------------------------
// dgsp_ctrl
// Sequencer: select, settle and relax loops of a run, and the path walk.
// ----------------------------------------------------------------------------
`default_nettype none

module dgsp_ctrl import dgsp_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [ActW-1:0] action_i,
  input  wire sts_t            sts_i,
  output cmd_t                 cmd_o,
  output logic                 idle_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_RELAX  = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_QUERY  = 3'd6;

  logic [2:0]      st_q, st_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] step_q, step_d;
  logic [CntW-1:0] n;
  logic            acc;

  assign n          = eff_count(cfg_i.vertex_count);
  assign in_stall_o = (st_q != S_IDLE);
  assign idle_o     = (st_q == S_IDLE);
  assign acc        = in_valid_i && (st_q == S_IDLE);

  always_comb begin
    st_d   = st_q;
    idx_d  = idx_q;
    step_d = step_q;
    cmd_o  = '0;
    cmd_o.idx = idx_q[VtxW-1:0];
    unique case (st_q)
      S_IDLE: begin
        if (acc) begin
          unique case (action_i)
            ACT_LOAD: cmd_o.load = 1'b1;
            ACT_RUN: begin
              cmd_o.clear_run = 1'b1;
              idx_d  = '0;
              step_d = '0;
              if ((CntW'(cfg_i.source_vertex) < n) && (n >= CntW'(2))) st_d = S_SCAN;
              else st_d = S_EMIT;
            end
            ACT_QUERY: begin
              cmd_o.q_start = 1'b1;
              st_d = S_QUERY;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_en    = 1'b1;
        cmd_o.scan_first = (idx_q == '0);
        if (idx_q == n - CntW'(1)) begin
          idx_d = '0;
          st_d  = S_DECIDE;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      S_DECIDE: begin
        if (sts_i.found && sts_i.best_lt_cap) begin
          cmd_o.settle = 1'b1;
          idx_d = '0;
          st_d  = S_RELAX;
        end else begin
          st_d = S_EMIT;
        end
      end
      S_RELAX: begin
        cmd_o.rd_en = 1'b1;
        if (idx_q == n - CntW'(1)) begin
          idx_d = '0;
          st_d  = S_DRAIN;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      S_DRAIN: begin
        if (step_q + CntW'(2) < n) begin
          step_d = step_q + CntW'(1);
          st_d   = S_SCAN;
        end else begin
          st_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_run = 1'b1;
          st_d = S_IDLE;
        end
      end
      S_QUERY: begin
        if (sts_i.out_free) begin
          cmd_o.q_emit = 1'b1;
          if (!sts_i.more) st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      idx_q  <= '0;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dgsp_dp.sv
// ----------------------------------------------------------------------------
// dgsp_dp
// Datapath: weight memory, distance and parent tables, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dgsp_dp import dgsp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire cmd_t             cmd_i,
  output sts_t                  sts_o,
  input  wire logic [VtxW-1:0]  row_vertex_i,
  input  wire logic [VtxW-1:0]  col_vertex_i,
  input  wire logic [WgtW-1:0]  edge_weight_i,
  input  wire logic [VtxW-1:0]  dest_vertex_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  out_kind_o,
  output logic [VtxW-1:0]       out_vertex_o,
  output logic [DistW-1:0]      out_distance_o,
  output logic                  out_reachable_o,
  output logic                  out_last_o
);

  logic [WgtW-1:0]  wmem [MaxVertices*MaxVertices];
  logic [WgtW-1:0]  wrd_q;
  logic [DistW-1:0] dist_q [MaxVertices];
  logic [VtxW:0]    par_q  [MaxVertices];
  logic [MaxVertices-1:0] settled_q;

  logic [DistW-1:0] best_q;
  logic [VtxW-1:0]  u_q;
  logic             found_q;
  logic             rlx_vld_q;
  logic [VtxW-1:0]  j_q;
  logic [VtxW-1:0]  v_q;
  logic [KW-1:0]    k_q;
  logic             reach_q;

  logic             ov_q;
  logic             okind_q, oreach_q, olast_q;
  logic [VtxW-1:0]  ovtx_q;
  logic [DistW-1:0] odist_q;

  logic [VtxW-1:0]  raddr;
  logic [DistW-1:0] rdist;
  logic [VtxW:0]    rpar;
  logic [DistW-1:0] cur_best;
  logic             take_scan;
  logic [DistW:0]   sum_w;
  logic [DistW-1:0] sum;
  logic             upd;
  logic             reach_now;
  logic [CntW-1:0]  n;

  assign n = eff_count(cfg_i.vertex_count);

  always_comb begin
    priority if (rlx_vld_q) raddr = j_q;
    else if (cmd_i.scan_en) raddr = cmd_i.idx;
    else raddr = v_q;
  end
  assign rdist = dist_q[raddr];
  assign rpar  = par_q[raddr];

  assign cur_best  = cmd_i.scan_first ? cfg_i.no_path_value : best_q;
  assign take_scan = !settled_q[cmd_i.idx] && (rdist <= cur_best);

  assign sum_w = {1'b0, best_q} + (DistW+1)'(wrd_q);
  assign sum   = (sum_w > (DistW+1)'(cfg_i.no_path_value)) ? cfg_i.no_path_value
                                                            : sum_w[DistW-1:0];
  assign upd   = rlx_vld_q && !settled_q[j_q] && (DistW'(wrd_q) < cfg_i.no_path_value)
                 && (sum < rdist);

  assign reach_now = (k_q == '0) ? (rdist < cfg_i.no_path_value) : reach_q;

  assign sts_o.found       = found_q;
  assign sts_o.best_lt_cap = best_q < cfg_i.no_path_value;
  assign sts_o.out_free    = !ov_q || !out_stall_i;
  assign sts_o.more        = !rpar[VtxW] && (k_q != {KW{1'b1}});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) wmem[{row_vertex_i, col_vertex_i}] <= edge_weight_i;
    if (cmd_i.rd_en) wrd_q <= wmem[{u_q, cmd_i.idx}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxVertices; i++) begin
        dist_q[i] <= CapReset;
        par_q[i]  <= ParentNone;
      end
      settled_q <= '0;
      rlx_vld_q <= 1'b0;
      found_q   <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      rlx_vld_q <= cmd_i.rd_en;
      if (cmd_i.clear_run) begin
        for (int i = 0; i < MaxVertices; i++) begin
          dist_q[i] <= ((VtxW'(i) == cfg_i.source_vertex) &&
                        (CntW'(cfg_i.source_vertex) < n)) ? '0 : cfg_i.no_path_value;
          par_q[i]  <= ParentNone;
        end
        settled_q <= '0;
      end
      if (cmd_i.scan_en) begin
        if (take_scan) found_q <= 1'b1;
        else if (cmd_i.scan_first) found_q <= 1'b0;
      end
      if (cmd_i.settle) settled_q[u_q] <= 1'b1;
      if (upd) begin
        dist_q[j_q] <= sum;
        par_q[j_q]  <= {1'b0, u_q};
      end
      if (cmd_i.emit_run || cmd_i.q_emit) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      if (take_scan) begin
        best_q <= rdist;
        u_q    <= cmd_i.idx;
      end else if (cmd_i.scan_first) begin
        best_q <= cfg_i.no_path_value;
        u_q    <= '0;
      end
    end
    j_q <= cmd_i.idx;
    if (cmd_i.q_start) begin
      v_q <= dest_vertex_i;
      k_q <= '0;
    end else if (cmd_i.q_emit) begin
      v_q     <= rpar[VtxW-1:0];
      k_q     <= k_q + KW'(1);
      reach_q <= reach_now;
    end
    if (cmd_i.emit_run) begin
      okind_q  <= KIND_RUN;
      ovtx_q   <= cfg_i.source_vertex;
      odist_q  <= '0;
      oreach_q <= CntW'(cfg_i.source_vertex) < n;
      olast_q  <= 1'b1;
    end else if (cmd_i.q_emit) begin
      okind_q  <= KIND_PATH;
      ovtx_q   <= v_q;
      odist_q  <= rdist;
      oreach_q <= reach_now;
      olast_q  <= !sts_o.more;
    end
  end

  assign out_valid_o     = ov_q;
  assign out_kind_o      = okind_q;
  assign out_vertex_o    = ovtx_q;
  assign out_distance_o  = odist_q;
  assign out_reachable_o = oreach_q;
  assign out_last_o      = olast_q;

endmodule

`default_nettype wire

>>> rtl/dense_graph_shortest_path.sv
// ----------------------------------------------------------------------------
// dense_graph_shortest_path
// Single-source shortest paths over a dense weight matrix.
// ----------------------------------------------------------------------------
// Run: per settled vertex a scan of all N vertices and a relax pass through
// the one weight memory port, then the result. Query: unless the output
// stalls, one result per cycle for each path vertex, destination first.
// One request is worked at a time; the result register frees the input side.
// Reset clears control, distance and parent tables and restores the registers.
`default_nettype none

module dense_graph_shortest_path import dgsp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DistW-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ActW-1:0]    action_i,
  input  wire logic [VtxW-1:0]    row_vertex_i,
  input  wire logic [VtxW-1:0]    col_vertex_i,
  input  wire logic [WgtW-1:0]    edge_weight_i,
  input  wire logic [VtxW-1:0]    dest_vertex_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    kind_o,
  output logic [VtxW-1:0]         vertex_o,
  output logic [DistW-1:0]        distance_o,
  output logic                    reachable_o,
  output logic                    last_o
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vertex_count  <= CountReset;
      cfg_q.source_vertex <= '0;
      cfg_q.no_path_value <= CapReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_COUNT:  cfg_q.vertex_count  <= cfg_wdata_i[CntW-1:0];
        REG_SOURCE: cfg_q.source_vertex <= cfg_wdata_i[VtxW-1:0];
        REG_CAP:    cfg_q.no_path_value <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dgsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  dgsp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .row_vertex_i    (row_vertex_i),
    .col_vertex_i    (col_vertex_i),
    .edge_weight_i   (edge_weight_i),
    .dest_vertex_i   (dest_vertex_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_kind_o      (kind_o),
    .out_vertex_o    (vertex_o),
    .out_distance_o  (distance_o),
    .out_reachable_o (reachable_o),
    .out_last_o      (last_o)
  );

  a_run_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_RUN) |-> (distance_o == '0) && last_o)
    else $error("run result malformed");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_RUN) |=> in_stall_o && !idle)
    else $error("run did not occupy the sequencer");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.clear_run, cmd.scan_en, cmd.settle, cmd.rd_en,
              cmd.emit_run, cmd.q_start, cmd.q_emit}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

>>> bench/dense_graph_shortest_path_tb.sv
// ----------------------------------------------------------------------------
// dense_graph_shortest_path_tb
// Self-checking bench: loads weight matrices, runs shortest-path searches and
// queries paths under several register settings, with random idle on both
// sides, and compares every result with an in-bench path predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_graph_shortest_path_tb;
  import dgsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles = 3000;
  localparam logic [ActW-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [VtxW-1:0]  vertex;
    logic [DistW-1:0] distance;
    logic             reachable;
    logic             last;
  } path_res_t;

  typedef struct packed {
    logic [ActW-1:0] act;
    logic [VtxW-1:0] row;
    logic [VtxW-1:0] col;
    logic [WgtW-1:0] wgt;
    logic [VtxW-1:0] dest;
    logic            typed;
    path_res_t       res;
  } req_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = REG_COUNT;
  logic [DistW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ActW-1:0] action_i = ACT_LOAD;
  logic [VtxW-1:0] row_vertex_i = '0;
  logic [VtxW-1:0] col_vertex_i = '0;
  logic [WgtW-1:0] edge_weight_i = '0;
  logic [VtxW-1:0] dest_vertex_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o;
  logic [VtxW-1:0] vertex_o;
  logic [DistW-1:0] distance_o;
  logic reachable_o;
  logic last_o;

  dense_graph_shortest_path i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .action_i, .row_vertex_i, .col_vertex_i,
    .edge_weight_i, .dest_vertex_i, .out_valid_o, .out_stall_i,
    .kind_o, .vertex_o, .distance_o, .reachable_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [CntW-1:0]  m_count = CountReset;
  logic [VtxW-1:0]  m_source = '0;
  logic [DistW-1:0] m_cap = CapReset;
  logic [WgtW-1:0]  m_wgt [MaxVertices*MaxVertices];
  bit               m_written [MaxVertices*MaxVertices];
  logic [DistW-1:0] m_dist [MaxVertices];
  bit               m_done [MaxVertices];
  logic [VtxW:0]    m_par [MaxVertices];

  path_res_t expected_paths[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  bit hold_go = 1'b0;
  bit hold_on = 1'b0;

  function automatic void clear_search();
    for (int i = 0; i < MaxVertices; i++) begin
      m_dist[i] = m_cap;
      m_done[i] = 1'b0;
      m_par[i] = ParentNone;
    end
  endfunction

  // returns the first settled vertex whose row is not fully loaded, else -1
  function automatic int search_paths();
    int unsigned n;
    int unsigned u;
    logic [DistW-1:0] best;
    logic [DistW:0] sum;
    logic [WgtW-1:0] w;
    bit found;
    n = (m_count > MaxVertices) ? MaxVertices : m_count;
    clear_search();
    if (m_source >= n) return -1;
    m_dist[m_source] = '0;
    for (int step = 0; step + 1 < n; step++) begin
      best = m_cap;
      u = 0;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!m_done[i] && m_dist[i] <= best) begin
          best = m_dist[i];
          u = i;
          found = 1'b1;
        end
      end
      if (!found || m_dist[u] >= m_cap) break;
      m_done[u] = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (!m_written[u*MaxVertices + i]) return int'(u);
      end
      for (int i = 0; i < n; i++) begin
        w = m_wgt[u*MaxVertices + i];
        if (m_done[i] || {6'd0, w} >= m_cap) continue;
        sum = {1'b0, m_dist[u]} + (DistW+1)'(w);
        if (sum > {1'b0, m_cap}) sum = {1'b0, m_cap};
        if (sum[DistW-1:0] < m_dist[i]) begin
          m_dist[i] = sum[DistW-1:0];
          m_par[i] = (VtxW+1)'(u);
        end
      end
    end
    return -1;
  endfunction

  function automatic void predict_paths(input req_row_t r);
    int unsigned n;
    int unsigned v;
    int unsigned k;
    logic [VtxW:0] nxt;
    logic reach;
    bit more;
    path_res_t e;
    case (r.act)
      ACT_LOAD: begin
        m_wgt[r.row*MaxVertices + r.col] = r.wgt;
        m_written[r.row*MaxVertices + r.col] = 1'b1;
      end
      ACT_RUN: begin
        n = (m_count > MaxVertices) ? MaxVertices : m_count;
        void'(search_paths());
        e = '{KIND_RUN, m_source, '0, (m_source < n), 1'b1};
        expected_paths.push_back(e);
      end
      ACT_QUERY: begin
        reach = m_dist[r.dest] < m_cap;
        v = r.dest;
        k = 0;
        forever begin
          nxt = m_par[v];
          more = nxt != ParentNone && nxt < MaxVertices && k + 1 < ResultLimit;
          e = '{KIND_PATH, v[VtxW-1:0], m_dist[v], reach, !more};
          expected_paths.push_back(e);
          k++;
          if (!more) break;
          v = nxt;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic offer(input req_row_t r);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= r.act;
    row_vertex_i <= r.row;
    col_vertex_i <= r.col;
    edge_weight_i <= r.wgt;
    dest_vertex_i <= r.dest;
    if (r.typed) begin
      if (r.act == ACT_LOAD) predict_paths(r);
      else if (r.act == ACT_RUN) void'(search_paths());
      expected_paths.push_back(r.res);
    end else begin
      predict_paths(r);
    end
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [WgtW-1:0] pick_weight();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return WgtW'($urandom_range(63));
      3: return WgtW'($urandom_range(2000));
      default: return WgtW'($urandom);
    endcase
  endfunction

  // load the missing rows that the coming search will read
  task automatic fill_weights();
    int unsigned n;
    int row;
    req_row_t r;
    n = (m_count > MaxVertices) ? MaxVertices : m_count;
    row = search_paths();
    while (row >= 0) begin
      for (int b = 0; b < n; b++) begin
        if (!m_written[row*MaxVertices + b]) begin
          r = '0;
          r.act = ACT_LOAD;
          r.row = VtxW'(row);
          r.col = VtxW'(b);
          r.wgt = '1;
          offer(r);
        end
      end
      row = search_paths();
    end
  endtask

  task automatic issue(input req_row_t r);
    if (r.act == ACT_RUN) fill_weights();
    offer(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_paths.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DistW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_COUNT:  m_count = val[CntW-1:0];
      REG_SOURCE: m_source = val[VtxW-1:0];
      REG_CAP:    m_cap = val;
      default: ;
    endcase
  endtask

  task automatic set_graph(input int unsigned n, input int unsigned src,
                           input logic [DistW-1:0] cap);
    drain();
    write_reg(REG_COUNT, DistW'(n));
    write_reg(REG_SOURCE, DistW'(src));
    write_reg(REG_CAP, cap);
  endtask

  task automatic random_phase(input int unsigned items);
    req_row_t r;
    int unsigned n;
    int unsigned roll;
    n = (m_count > MaxVertices) ? MaxVertices : m_count;
    for (int j = 0; j < items; j++) begin
      r = '0;
      roll = $urandom_range(99);
      r.row = VtxW'($urandom);
      r.col = VtxW'($urandom);
      r.wgt = pick_weight();
      r.dest = ($urandom_range(3) == 0) ? VtxW'($urandom) : VtxW'($urandom_range(n - 1));
      if (roll < 15) r.act = ACT_RUN;
      else if (roll < 55) r.act = ACT_QUERY;
      else if (roll < 95) begin
        r.act = ACT_LOAD;
        if ($urandom_range(3) != 0) begin
          r.row = VtxW'($urandom_range(n - 1));
          r.col = VtxW'($urandom_range(n - 1));
        end
      end else r.act = ACT_SPARE;
      issue(r);
    end
  endtask

  req_row_t directed [] = '{
    '{ACT_QUERY, 5'd0, 5'd0, 18'd0, 5'd5, 1'b1, '{KIND_PATH, 5'd5, CapReset, 1'b0, 1'b1}},
    '{ACT_QUERY, 5'd0, 5'd0, 18'd0, 5'd31, 1'b1, '{KIND_PATH, 5'd31, CapReset, 1'b0, 1'b1}},
    '{ACT_SPARE, 5'd31, 5'd31, 18'h3FFFF, 5'd31, 1'b0, '0},
    '{ACT_LOAD, 5'd0, 5'd1, 18'd0, 5'd0, 1'b0, '0},
    '{ACT_LOAD, 5'd1, 5'd2, 18'h3FFFF, 5'd0, 1'b0, '0},
    '{ACT_LOAD, 5'd2, 5'd3, 18'd255744, 5'd0, 1'b0, '0},
    '{ACT_LOAD, 5'd0, 5'd2, 18'd5, 5'd0, 1'b0, '0},
    '{ACT_LOAD, 5'd1, 5'd3, 18'd7, 5'd0, 1'b0, '0},
    '{ACT_LOAD, 5'd0, 5'd3, 18'd7, 5'd0, 1'b0, '0},
    '{ACT_LOAD, 5'd31, 5'd31, 18'h3FFFF, 5'd0, 1'b0, '0},
    '{ACT_LOAD, 5'd31, 5'd0, 18'd0, 5'd0, 1'b0, '0},
    '{ACT_RUN, 5'd0, 5'd0, 18'd0, 5'd0, 1'b1, '{KIND_RUN, 5'd0, 24'd0, 1'b1, 1'b1}},
    '{ACT_QUERY, 5'd0, 5'd0, 18'd0, 5'd0, 1'b1, '{KIND_PATH, 5'd0, 24'd0, 1'b1, 1'b1}},
    '{ACT_QUERY, 5'd0, 5'd0, 18'd0, 5'd3, 1'b0, '0},
    '{ACT_QUERY, 5'd0, 5'd0, 18'd0, 5'd2, 1'b0, '0},
    '{ACT_QUERY, 5'd0, 5'd0, 18'd0, 5'd17, 1'b0, '0},
    '{ACT_QUERY, 5'd0, 5'd0, 18'd0, 5'd31, 1'b0, '0}
  };

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_paths.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d vertex %0d distance %0d", kind_o,
                     vertex_o, distance_o);
        end else begin
          path_res_t e;
          e = expected_paths.pop_front();
          if (e != {kind_o, vertex_o, distance_o, reachable_o, last_o}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp k%0d v%0d d%0d r%0d l%0d got k%0d v%0d d%0d r%0d l%0d",
                       e.kind, e.vertex, e.distance, e.reachable, e.last,
                       kind_o, vertex_o, distance_o, reachable_o, last_o);
          end
        end
      end
      if (hold_on) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle);
      end
    end
  end

  // hold off the result side for a long stretch
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("dense_graph_shortest_path_tb: FAIL");
      $finish;
    end
  end

  initial begin
    clear_search();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    snd_idle = 25;
    rcv_idle = 57;
    foreach (directed[i]) issue(directed[i]);

    set_graph(2, 1, 24'hFFFFFF);
    random_phase(20);
    set_graph(32, 31, 24'd1);
    random_phase(20);
    set_graph(4, 31, CapReset);
    random_phase(20);
    snd_idle = 57;
    rcv_idle = 25;
    set_graph(8, 3, 24'd1000);
    random_phase(20);
    set_graph(63, 5, 24'd262143);
    hold_go = 1'b1;
    random_phase(20);
    snd_idle = 0;
    rcv_idle = 0;
    set_graph(12, 0, 24'd2500);
    random_phase(20);
    set_graph($urandom_range(2, 32), $urandom_range(31), DistW'($urandom_range(1, 262143)));
    random_phase(20);
    set_graph($urandom_range(2, 20), $urandom_range(19), DistW'($urandom_range(1, 262143)));
    random_phase(20);
    drain();

    if (mismatches == 0 && expected_paths.size() == 0) begin
      $display("dense_graph_shortest_path_tb: PASS");
    end else begin
      $display("dense_graph_shortest_path_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
